// File: rtl/wsat_pkg.sv
// Shared types, constants and helpers of the station association table.
package wsat_pkg;

  localparam int MAX_STATIONS = 16;
  localparam int MAX_RESULTS  = 17;
  localparam int MAX_DELETES  = MAX_RESULTS - 1;
  localparam int IDX_W        = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int CNT_W        = $clog2(MAX_DELETES + 1);
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam int CMD_W    = 3;
  localparam int MAC_W    = 48;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int STATE_W  = 2;
  localparam int TIMER_W  = 16;
  localparam int RADIO_W  = 5;
  localparam int CFG_IDX_W = 1;

  // command codes on the input
  localparam logic [CMD_W-1:0] CMD_AUTH     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ASSOC    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISASSOC = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEAUTH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RADIO    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_STATE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_TICK_DONE = 3'd4;

  // station states
  localparam logic [STATE_W-1:0] ST_OFF   = 2'd0;
  localparam logic [STATE_W-1:0] ST_AUTH  = 2'd1;
  localparam logic [STATE_W-1:0] ST_ASSOC = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIO   = 1'b1;

  localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd10;
  localparam logic [RADIO_W-1:0] RADIO_RST   = 5'd0;

  typedef enum logic [2:0] {
    OP_AUTH,
    OP_ASSOC,
    OP_DISASSOC,
    OP_DEAUTH,
    OP_RADIO,
    OP_TICK,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [MAC_W-1:0] mac;
  } req_t;

  typedef struct packed {
    logic [TIMER_W-1:0] timeout;
    logic [RADIO_W-1:0] radio;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] state;
    logic               on_radio;
    logic [TIMER_W-1:0] timer;
    logic               running;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [STATE_W-1:0]  new_state;
    logic                delete_event;
    logic [MAC_W-1:0]    event_mac;
    logic [RADIO_W-1:0]  event_radio;
    logic                last;
  } res_t;

  // table index as seen in the 4-bit slot field
  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [63:0] w;
    w = 64'(idx);
    return w[SLOT_W-1:0];
  endfunction

endpackage

// File: rtl/wsat_front.sv
// Front end: takes requests and classifies the command into an operation.
module wsat_front (
  input  logic                      in_valid_i,
  input  logic [wsat_pkg::CMD_W-1:0] command_i,
  input  logic [wsat_pkg::MAC_W-1:0] station_mac_i,
  input  logic                      q_full_i,
  output logic                      in_stall_o,
  output logic                      push_o,
  output wsat_pkg::req_t            req_o
);

  wsat_pkg::op_e op;

  always_comb begin
    unique case (command_i)
      wsat_pkg::CMD_AUTH:     op = wsat_pkg::OP_AUTH;
      wsat_pkg::CMD_ASSOC:    op = wsat_pkg::OP_ASSOC;
      wsat_pkg::CMD_DISASSOC: op = wsat_pkg::OP_DISASSOC;
      wsat_pkg::CMD_DEAUTH:   op = wsat_pkg::OP_DEAUTH;
      wsat_pkg::CMD_RADIO:    op = wsat_pkg::OP_RADIO;
      wsat_pkg::CMD_TICK:     op = wsat_pkg::OP_TICK;
      default:                op = wsat_pkg::OP_BAD;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign req_o.op   = op;
  assign req_o.mac  = station_mac_i;

endmodule

// File: rtl/wsat_queue.sv
// Short request queue between the front end and the table engine.
module wsat_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wsat_pkg::req_t req_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output wsat_pkg::req_t req_o
);

  wsat_pkg::req_t mem_q [wsat_pkg::QDEPTH];
  logic [wsat_pkg::QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [wsat_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == wsat_pkg::QCNT_W'(wsat_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign req_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= req_i;
    end
  end

endmodule

// File: rtl/wsat_engine.sv
// Table engine: station table, sequential lookup and tick sweep, result register.
module wsat_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wsat_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  wsat_pkg::req_t q_req_i,
  output logic           pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output wsat_pkg::res_t res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_TDONE = 3'd4;

  localparam logic [wsat_pkg::IDX_W-1:0] LAST_IDX =
    wsat_pkg::IDX_W'(wsat_pkg::MAX_STATIONS - 1);
  localparam logic [wsat_pkg::CNT_W-1:0] DEL_MAX =
    wsat_pkg::CNT_W'(wsat_pkg::MAX_DELETES);

  wsat_pkg::entry_t             entry_q [wsat_pkg::MAX_STATIONS];
  logic [wsat_pkg::MAC_W-1:0]   mac_mem [wsat_pkg::MAX_STATIONS];

  logic [2:0]                   fsm_q, fsm_d;
  wsat_pkg::op_e                op_q, op_d;
  logic [wsat_pkg::MAC_W-1:0]   mac_q, mac_d;
  logic [wsat_pkg::IDX_W-1:0]   idx_q, idx_d, free_idx_q, free_idx_d;
  logic                         hit_q, hit_d, free_q, free_d;
  logic [wsat_pkg::CNT_W-1:0]   del_q, del_d;
  logic                         out_valid_q, out_valid_d;
  wsat_pkg::res_t               res_q, res_d;

  wsat_pkg::entry_t             cur, ent_d;
  logic [wsat_pkg::MAC_W-1:0]   mac_rd;
  logic                         ent_we, mac_we, res_we, advance;
  logic                         emit_ok, last_idx, match, is_free;
  logic [wsat_pkg::STATE_W-1:0] dis_state;

  assign cur      = entry_q[idx_q];
  assign mac_rd   = mac_mem[idx_q];
  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign last_idx = (idx_q == LAST_IDX);
  assign match    = cur.valid && (mac_rd == mac_q);
  assign is_free  = !cur.valid || (cur.state == wsat_pkg::ST_OFF);
  assign dis_state = (cur.state == wsat_pkg::ST_ASSOC) ? wsat_pkg::ST_AUTH : cur.state;

  always_comb begin
    fsm_d      = fsm_q;
    op_d       = op_q;
    mac_d      = mac_q;
    idx_d      = idx_q;
    free_idx_d = free_idx_q;
    hit_d      = hit_q;
    free_d     = free_q;
    del_d      = del_q;
    pop_o      = 1'b0;
    ent_we     = 1'b0;
    ent_d      = cur;
    mac_we     = 1'b0;
    res_we     = 1'b0;
    res_d      = '0;
    advance    = 1'b0;

    unique case (fsm_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          op_d   = q_req_i.op;
          mac_d  = q_req_i.mac;
          idx_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          del_d  = '0;
          if (q_req_i.op == wsat_pkg::OP_TICK) begin
            fsm_d = S_TICK;
          end else if (q_req_i.op == wsat_pkg::OP_BAD) begin
            fsm_d = S_APPLY;
          end else begin
            fsm_d = S_SCAN;
          end
        end
      end

      // one entry per cycle; lowest match stops, lowest free slot is noted
      S_SCAN: begin
        if (match) begin
          hit_d = 1'b1;
          fsm_d = S_APPLY;
        end else begin
          if (is_free && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_q;
          end
          if (last_idx) begin
            fsm_d = S_APPLY;
            idx_d = free_q ? free_idx_q : idx_q;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      // idx_q points at the hit entry, or at the free slot on a miss
      S_APPLY: begin
        if (emit_ok) begin
          res_we          = 1'b1;
          fsm_d           = S_IDLE;
          res_d.last      = 1'b1;
          res_d.event_mac = mac_q;
          res_d.status    = wsat_pkg::STS_OK;
          res_d.slot      = wsat_pkg::slot_field(idx_q);
          if (op_q == wsat_pkg::OP_BAD) begin
            res_d.status = wsat_pkg::STS_BAD_STATE;
            res_d.slot   = '0;
          end else if (op_q == wsat_pkg::OP_AUTH) begin
            if (hit_q || free_q) begin
              ent_we = 1'b1;
              if (!hit_q) begin
                ent_d.valid    = 1'b1;
                ent_d.on_radio = 1'b0;
                mac_we         = 1'b1;
              end
              ent_d.state     = wsat_pkg::ST_AUTH;
              ent_d.timer     = cfg_i.timeout;
              ent_d.running   = 1'b1;
              res_d.new_state = wsat_pkg::ST_AUTH;
            end else begin
              res_d.status = wsat_pkg::STS_FULL;
              res_d.slot   = '0;
            end
          end else if (!hit_q) begin
            res_d.status = wsat_pkg::STS_NOT_FOUND;
            res_d.slot   = '0;
          end else begin
            unique case (op_q)
              wsat_pkg::OP_ASSOC: begin
                if (cur.state == wsat_pkg::ST_AUTH || cur.state == wsat_pkg::ST_ASSOC) begin
                  ent_we          = 1'b1;
                  ent_d.state     = wsat_pkg::ST_ASSOC;
                  res_d.new_state = wsat_pkg::ST_ASSOC;
                end else begin
                  res_d.status    = wsat_pkg::STS_BAD_STATE;
                  res_d.new_state = cur.state;
                end
              end
              wsat_pkg::OP_DISASSOC: begin
                ent_we          = 1'b1;
                ent_d.state     = dis_state;
                ent_d.timer     = cfg_i.timeout;
                ent_d.running   = 1'b1;
                res_d.new_state = dis_state;
              end
              wsat_pkg::OP_DEAUTH: begin
                if (cur.on_radio) begin
                  ent_we             = 1'b1;
                  ent_d              = '0;
                  res_d.new_state    = wsat_pkg::ST_OFF;
                  res_d.delete_event = 1'b1;
                  res_d.event_radio  = cfg_i.radio;
                end else begin
                  res_d.new_state = cur.state;
                end
              end
              wsat_pkg::OP_RADIO: begin
                ent_we          = 1'b1;
                ent_d.on_radio  = 1'b1;
                res_d.new_state = cur.state;
              end
              default: begin
                res_d.new_state = cur.state;
              end
            endcase
          end
        end
      end

      // timer sweep; only a removal waits for the result register
      S_TICK: begin
        if (cur.valid && cur.running) begin
          if (cur.timer > wsat_pkg::TIMER_W'(1)) begin
            ent_we      = 1'b1;
            ent_d.timer = cur.timer - 1'b1;
            advance     = 1'b1;
          end else if (cur.state != wsat_pkg::ST_ASSOC && cur.on_radio) begin
            if (del_q == DEL_MAX) begin
              // removal stays pending for a later tick
              ent_we      = 1'b1;
              ent_d.timer = '0;
              advance     = 1'b1;
            end else if (emit_ok) begin
              ent_we             = 1'b1;
              ent_d              = '0;
              res_we             = 1'b1;
              res_d.status       = wsat_pkg::STS_OK;
              res_d.slot         = wsat_pkg::slot_field(idx_q);
              res_d.new_state    = wsat_pkg::ST_OFF;
              res_d.delete_event = 1'b1;
              res_d.event_mac    = mac_rd;
              res_d.event_radio  = cfg_i.radio;
              del_d              = del_q + 1'b1;
              advance            = 1'b1;
            end
          end else begin
            ent_we        = 1'b1;
            ent_d.timer   = '0;
            ent_d.running = 1'b0;
            advance       = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          if (last_idx) begin
            fsm_d = S_TDONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      S_TDONE: begin
        if (emit_ok) begin
          res_we       = 1'b1;
          res_d.status = wsat_pkg::STS_TICK_DONE;
          res_d.last   = 1'b1;
          fsm_d        = S_IDLE;
        end
      end

      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_we) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      del_q       <= '0;
      idx_q       <= '0;
      for (int i = 0; i < wsat_pkg::MAX_STATIONS; i++) begin
        entry_q[i] <= '0;
      end
    end else begin
      fsm_q       <= fsm_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      del_q       <= del_d;
      idx_q       <= idx_d;
      if (ent_we) begin
        entry_q[idx_q] <= ent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    mac_q      <= mac_d;
    free_idx_q <= free_idx_d;
    if (res_we) begin
      res_q <= res_d;
    end
    if (mac_we) begin
      mac_mem[idx_q] <= mac_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/wifi_station_association_table.sv
// An event request is looked up in the table after acceptance; the lookup walks the
// table one entry per cycle and stops at a match. An undefined command skips the lookup.
// A tick sweeps all 16 entries, one per cycle while no removal waits on the output,
// then adds the tick-done result. The engine holds one request at a time, and
// a two-entry queue takes new requests while the engine works. Removals stall on output.
// Reset (rst_ni, async low) clears the table flags, queue and output; config returns to defaults.
module wifi_station_association_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [wsat_pkg::CMD_W-1:0]     command_i,
  input  logic [wsat_pkg::MAC_W-1:0]     station_mac_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wsat_pkg::STATUS_W-1:0]  status_o,
  output logic [wsat_pkg::SLOT_W-1:0]    slot_o,
  output logic [wsat_pkg::STATE_W-1:0]   new_state_o,
  output logic                           delete_event_o,
  output logic [wsat_pkg::MAC_W-1:0]     event_mac_o,
  output logic [wsat_pkg::RADIO_W-1:0]   event_radio_o,
  output logic                           last_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wsat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wsat_pkg::TIMER_W-1:0]   cfg_data_i
);

  wsat_pkg::cfg_t cfg_q;
  wsat_pkg::req_t push_req, q_req;
  wsat_pkg::res_t res;
  logic           push, pop, q_full, q_valid;

  // config regs always take a write; to be written only while idle (the block does not enforce this)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= wsat_pkg::TIMEOUT_RST;
      cfg_q.radio   <= wsat_pkg::RADIO_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wsat_pkg::CFG_TIMEOUT: cfg_q.timeout <= cfg_data_i;
        wsat_pkg::CFG_RADIO:   cfg_q.radio   <= cfg_data_i[wsat_pkg::RADIO_W-1:0];
        default:               cfg_q         <= cfg_q;
      endcase
    end
  end

  // front end: decode command, push into queue
  wsat_front u_front (
    .in_valid_i    (in_valid_i),
    .command_i     (command_i),
    .station_mac_i (station_mac_i),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .req_o         (push_req)
  );

  wsat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .req_o   (q_req)
  );

  // back end: table lookup/update, tick sweep, result register
  wsat_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign status_o       = res.status;
  assign slot_o         = res.slot;
  assign new_state_o    = res.new_state;
  assign delete_event_o = res.delete_event;
  assign event_mac_o    = res.event_mac;
  assign event_radio_o  = res.event_radio;
  assign last_o         = res.last;

endmodule

// File: rtl/wsat_checker.sv
// Port-level checker for the station association table, with its bind.
module wsat_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [wsat_pkg::STATUS_W-1:0] status_o,
  input  logic [wsat_pkg::STATE_W-1:0]  new_state_o,
  input  logic                          delete_event_o,
  input  logic [wsat_pkg::MAC_W-1:0]    event_mac_o,
  input  logic [wsat_pkg::RADIO_W-1:0]  event_radio_o,
  input  logic                          last_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_mac_o) && $stable(status_o))
    else $error("result changed while stalled");

  // a removal always reports ok and off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && delete_event_o |->
      status_o == wsat_pkg::STS_OK && new_state_o == wsat_pkg::ST_OFF)
    else $error("delete result with wrong status or state");

  // tick-done closes the tick and carries no station
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == wsat_pkg::STS_TICK_DONE |->
      last_o && !delete_event_o && event_mac_o == '0)
    else $error("malformed tick-done result");

  // radio id only on delete results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !delete_event_o |-> event_radio_o == '0)
    else $error("radio id on a non-delete result");

endmodule

bind wifi_station_association_table wsat_checker u_wsat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .new_state_o    (new_state_o),
  .delete_event_o (delete_event_o),
  .event_mac_o    (event_mac_o),
  .event_radio_o  (event_radio_o),
  .last_o         (last_o)
);

// File: tb/tb_top.sv
// Self-checking testbench of the station association table: directed rows, then random traffic.
`timescale 1ns / 100ps

module tb_top;
  import wsat_pkg::*;

  // Command codes outside the defined set; the block answers them with bad state.
  localparam logic [CMD_W-1:0] CMD_UNDEF6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF7 = 3'd7;

  localparam logic [MAC_W-1:0] MAC_ZERO = '0;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;
  localparam logic [MAC_W-1:0] MAC_MID  = 48'h0123_4567_89AB;

  localparam int MAC_POOL_SIZE = 20;   // more stations than slots, so the table fills up
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int NUM_PHASES    = 5;

  // Per-phase register settings and request counts of the random part.
  localparam int PH_TIMEOUT [NUM_PHASES] = '{10, 1, 0, 65535, 3};
  localparam int PH_RADIO   [NUM_PHASES] = '{0, 17, 5, 31, -1};   // -1: pick at random
  localparam int PH_LEN     [NUM_PHASES] = '{35, 35, 30, 40, 40};

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [MAC_W-1:0] mac;
    logic             typed;   // 1: the expected result is given in the row
    res_t             res;
  } dir_row_t;

  logic                 clk;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i;
  logic [MAC_W-1:0]     station_mac_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STATUS_W-1:0]  status_o;
  logic [SLOT_W-1:0]    slot_o;
  logic [STATE_W-1:0]   new_state_o;
  logic                 delete_event_o;
  logic [MAC_W-1:0]     event_mac_o;
  logic [RADIO_W-1:0]   event_radio_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [TIMER_W-1:0]   cfg_data_i;

  wifi_station_association_table uut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .station_mac_i  (station_mac_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .new_state_o    (new_state_o),
    .delete_event_o (delete_event_o),
    .event_mac_o    (event_mac_o),
    .event_radio_o  (event_radio_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Station table as the bench sees it, plus the registers it was last given.
  // ---------------------------------------------------------------------------
  logic               tbl_valid    [MAX_STATIONS];
  logic [MAC_W-1:0]   tbl_mac      [MAX_STATIONS];
  logic [STATE_W-1:0] tbl_state    [MAX_STATIONS];
  logic               tbl_on_radio [MAX_STATIONS];
  logic [TIMER_W-1:0] tbl_timer    [MAX_STATIONS];
  logic               tbl_running  [MAX_STATIONS];
  logic [TIMER_W-1:0] cur_timeout;
  logic [RADIO_W-1:0] cur_radio;

  res_t             event_results[$];     // results of the request just accepted
  res_t             awaited_results[$];   // results still owed by the block, oldest first
  dir_row_t         dir_rows[$];
  logic [MAC_W-1:0] mac_pool [MAC_POOL_SIZE];

  int n_errors;
  int n_sent;
  bit hold_long;   // asks the result side for one long stall
  bit quiet;       // last part of the run: no gaps, no stalls

  function automatic res_t mk_res(input logic [STATUS_W-1:0] status, input int slot,
                                  input logic [STATE_W-1:0] st, input logic del,
                                  input logic [MAC_W-1:0] mac, input logic [RADIO_W-1:0] radio,
                                  input logic last);
    res_t r;
    r.status       = status;
    r.slot         = SLOT_W'(slot);
    r.new_state    = st;
    r.delete_event = del;
    r.event_mac    = mac;
    r.event_radio  = radio;
    r.last         = last;
    return r;
  endfunction

  function automatic void drop_entry(input int i);
    tbl_valid[i]    = 1'b0;
    tbl_state[i]    = ST_OFF;
    tbl_on_radio[i] = 1'b0;
    tbl_timer[i]    = '0;
    tbl_running[i]  = 1'b0;
  endfunction

  // Applies one request to the table copy and leaves its results in event_results.
  function automatic void apply_station_event(input logic [CMD_W-1:0] cmd,
                                              input logic [MAC_W-1:0] mac);
    int hit;
    int n_del;
    event_results.delete();

    if (cmd == CMD_TICK) begin
      // Sweep in slot order; an expiry past the removal budget stays pending at zero.
      n_del = 0;
      for (int i = 0; i < MAX_STATIONS; i++) begin
        if (tbl_valid[i] && tbl_running[i]) begin
          if (tbl_timer[i] > 16'd1) begin
            tbl_timer[i]--;
          end else begin
            tbl_timer[i] = '0;
            if (tbl_state[i] != ST_ASSOC && tbl_on_radio[i]) begin
              if (n_del < MAX_DELETES) begin
                event_results.push_back(mk_res(STS_OK, i, ST_OFF, 1'b1, tbl_mac[i],
                                               cur_radio, 1'b0));
                n_del++;
                drop_entry(i);
              end
            end else begin
              tbl_running[i] = 1'b0;
            end
          end
        end
      end
      event_results.push_back(mk_res(STS_TICK_DONE, 0, ST_OFF, 1'b0, '0, '0, 1'b1));
      return;
    end

    if (cmd == CMD_UNDEF6 || cmd == CMD_UNDEF7) begin
      event_results.push_back(mk_res(STS_BAD_STATE, 0, ST_OFF, 1'b0, mac, '0, 1'b1));
      return;
    end

    hit = -1;
    for (int i = 0; i < MAX_STATIONS; i++)
      if (hit < 0 && tbl_valid[i] && tbl_mac[i] == mac) hit = i;

    if (cmd == CMD_AUTH) begin
      if (hit < 0) begin
        for (int i = 0; i < MAX_STATIONS; i++)
          if (hit < 0 && (!tbl_valid[i] || tbl_state[i] == ST_OFF)) hit = i;
        if (hit < 0) begin
          event_results.push_back(mk_res(STS_FULL, 0, ST_OFF, 1'b0, mac, '0, 1'b1));
          return;
        end
        tbl_valid[hit]    = 1'b1;
        tbl_mac[hit]      = mac;
        tbl_on_radio[hit] = 1'b0;
      end
      tbl_state[hit]   = ST_AUTH;
      tbl_timer[hit]   = cur_timeout;
      tbl_running[hit] = 1'b1;
      event_results.push_back(mk_res(STS_OK, hit, ST_AUTH, 1'b0, mac, '0, 1'b1));
      return;
    end

    if (hit < 0) begin
      event_results.push_back(mk_res(STS_NOT_FOUND, 0, ST_OFF, 1'b0, mac, '0, 1'b1));
      return;
    end

    case (cmd)
      CMD_ASSOC: begin
        if (tbl_state[hit] == ST_AUTH || tbl_state[hit] == ST_ASSOC) begin
          tbl_state[hit] = ST_ASSOC;
          event_results.push_back(mk_res(STS_OK, hit, ST_ASSOC, 1'b0, mac, '0, 1'b1));
        end else begin
          event_results.push_back(mk_res(STS_BAD_STATE, hit, tbl_state[hit], 1'b0, mac,
                                         '0, 1'b1));
        end
      end
      CMD_DISASSOC: begin
        if (tbl_state[hit] == ST_ASSOC) tbl_state[hit] = ST_AUTH;
        tbl_timer[hit]   = cur_timeout;
        tbl_running[hit] = 1'b1;
        event_results.push_back(mk_res(STS_OK, hit, tbl_state[hit], 1'b0, mac, '0, 1'b1));
      end
      CMD_DEAUTH: begin
        if (tbl_on_radio[hit]) begin
          drop_entry(hit);
          event_results.push_back(mk_res(STS_OK, hit, ST_OFF, 1'b1, mac, cur_radio, 1'b1));
        end else begin
          event_results.push_back(mk_res(STS_OK, hit, tbl_state[hit], 1'b0, mac, '0, 1'b1));
        end
      end
      default: begin   // radio added
        tbl_on_radio[hit] = 1'b1;
        event_results.push_back(mk_res(STS_OK, hit, tbl_state[hit], 1'b0, mac, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [MAC_W-1:0] mac,
                                  input logic typed, input res_t res);
    dir_row_t r;
    r.cmd   = cmd;
    r.mac   = mac;
    r.typed = typed;
    r.res   = res;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Every task below is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [MAC_W-1:0] mac,
                          input logic typed, input res_t typed_res);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    station_mac_i <= mac;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    // request taken at this edge
    apply_station_event(cmd, mac);
    if (typed) awaited_results.push_back(typed_res);
    else foreach (event_results[k]) awaited_results.push_back(event_results[k]);
  endtask

  task automatic drive_rand(input logic [CMD_W-1:0] cmd, input logic [MAC_W-1:0] mac);
    send_req(cmd, mac, 1'b0, '0);
    n_sent++;
  endtask

  // Stop offering requests until the block has delivered everything, then let it settle.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIMER_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    if (idx == CFG_TIMEOUT) cur_timeout = data;
    else cur_radio = data[RADIO_W-1:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly station lifecycles (auth, radio added, assoc) on a small MAC pool, with
  // ticks, teardown events, unknown stations and undefined commands mixed in.
  task automatic random_traffic(input int n_items);
    int               pick;
    int               stop_at;
    logic [MAC_W-1:0] m;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      m    = mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
      if (pick < 40) begin
        drive_rand(CMD_AUTH, m);
        if ($urandom_range(0, 4) != 0) drive_rand(CMD_RADIO, m);
        if ($urandom_range(0, 2) != 0) drive_rand(CMD_ASSOC, m);
      end else if (pick < 68) begin
        drive_rand(CMD_TICK, {16'($urandom), 32'($urandom)});
      end else if (pick < 77) begin
        drive_rand(CMD_DEAUTH, m);
      end else if (pick < 84) begin
        drive_rand(CMD_DISASSOC, m);
      end else if (pick < 90) begin
        drive_rand(CMD_ASSOC, m);
      end else if (pick < 94) begin
        drive_rand(CMD_RADIO, m);
      end else if (pick < 97) begin
        drive_rand($urandom_range(0, 1) ? CMD_UNDEF7 : CMD_UNDEF6, m);
      end else begin
        // station never seen before
        drive_rand(CMD_ASSOC + CMD_W'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)});
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("wifi_station_association_table test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, one long hold on request, none when quiet.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      n_errors++;
    end
  endtask

  // Each result taken at an edge is compared with the oldest outstanding one.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result with none outstanding: status %0d slot %0d mac %0h",
               status_o, slot_o, event_mac_o);
        n_errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", MAC_W'(want.status), MAC_W'(status_o));
        check_field("slot", MAC_W'(want.slot), MAC_W'(slot_o));
        check_field("new_state", MAC_W'(want.new_state), MAC_W'(new_state_o));
        check_field("delete_event", MAC_W'(want.delete_event), MAC_W'(delete_event_o));
        check_field("event_mac", want.event_mac, event_mac_o);
        check_field("event_radio", MAC_W'(want.event_radio), MAC_W'(event_radio_o));
        check_field("last", MAC_W'(want.last), MAC_W'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_AUTH;
    station_mac_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_TIMEOUT;
    cfg_data_i    = '0;
    n_errors      = 0;
    n_sent        = 0;
    hold_long     = 1'b0;
    quiet         = 1'b0;
    cur_timeout   = TIMEOUT_RST;
    cur_radio     = RADIO_RST;
    for (int i = 0; i < MAX_STATIONS; i++) begin
      tbl_mac[i] = '0;
      drop_entry(i);
    end

    // pool holds both all-zero and all-one MACs so every address bit toggles
    mac_pool[0] = MAC_ZERO;
    mac_pool[1] = MAC_ONES;
    for (int i = 2; i < MAC_POOL_SIZE; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};

    // Directed rows run with a 2-tick timeout and the top radio id.
    // Typed rows carry their single result; the rest go through the table copy.
    add_row(CMD_TICK, MAC_ONES, 1'b1,
            mk_res(STS_TICK_DONE, 0, ST_OFF, 1'b0, '0, '0, 1'b1));
    add_row(CMD_ASSOC, MAC_ZERO, 1'b1,
            mk_res(STS_NOT_FOUND, 0, ST_OFF, 1'b0, MAC_ZERO, '0, 1'b1));
    add_row(CMD_AUTH, MAC_ZERO, 1'b1, mk_res(STS_OK, 0, ST_AUTH, 1'b0, MAC_ZERO, '0, 1'b1));
    add_row(CMD_AUTH, MAC_ONES, 1'b1, mk_res(STS_OK, 1, ST_AUTH, 1'b0, MAC_ONES, '0, 1'b1));
    add_row(CMD_ASSOC, MAC_ZERO, 1'b1, mk_res(STS_OK, 0, ST_ASSOC, 1'b0, MAC_ZERO, '0, 1'b1));
    // reassociation of an associated station
    add_row(CMD_ASSOC, MAC_ZERO, 1'b1, mk_res(STS_OK, 0, ST_ASSOC, 1'b0, MAC_ZERO, '0, 1'b1));
    add_row(CMD_RADIO, MAC_ZERO, 1'b1, mk_res(STS_OK, 0, ST_ASSOC, 1'b0, MAC_ZERO, '0, 1'b1));
    add_row(CMD_RADIO, MAC_ONES, 1'b1, mk_res(STS_OK, 1, ST_AUTH, 1'b0, MAC_ONES, '0, 1'b1));
    add_row(CMD_DISASSOC, MAC_ZERO, 1'b1,
            mk_res(STS_OK, 0, ST_AUTH, 1'b0, MAC_ZERO, '0, 1'b1));
    add_row(CMD_DEAUTH, MAC_MID, 1'b1,
            mk_res(STS_NOT_FOUND, 0, ST_OFF, 1'b0, MAC_MID, '0, 1'b1));
    add_row(CMD_AUTH, MAC_MID, 1'b1, mk_res(STS_OK, 2, ST_AUTH, 1'b0, MAC_MID, '0, 1'b1));
    // disassoc while only authenticated: state kept, timer restarted
    add_row(CMD_DISASSOC, MAC_MID, 1'b1, mk_res(STS_OK, 2, ST_AUTH, 1'b0, MAC_MID, '0, 1'b1));
    // deauth of a station never added to the radio changes nothing
    add_row(CMD_DEAUTH, MAC_MID, 1'b1, mk_res(STS_OK, 2, ST_AUTH, 1'b0, MAC_MID, '0, 1'b1));
    add_row(CMD_UNDEF6, MAC_MID, 1'b1,
            mk_res(STS_BAD_STATE, 0, ST_OFF, 1'b0, MAC_MID, '0, 1'b1));
    add_row(CMD_UNDEF7, MAC_ONES, 1'b1,
            mk_res(STS_BAD_STATE, 0, ST_OFF, 1'b0, MAC_ONES, '0, 1'b1));
    add_row(CMD_DEAUTH, MAC_ONES, 1'b1,
            mk_res(STS_OK, 1, ST_OFF, 1'b1, MAC_ONES, 5'd31, 1'b1));
    // freed slot is reused; radio flag starts cleared
    add_row(CMD_AUTH, MAC_ONES, 1'b1, mk_res(STS_OK, 1, ST_AUTH, 1'b0, MAC_ONES, '0, 1'b1));
    add_row(CMD_RADIO, MAC_ONES, 1'b1, mk_res(STS_OK, 1, ST_AUTH, 1'b0, MAC_ONES, '0, 1'b1));
    // re-auth of a known station keeps its radio flag
    add_row(CMD_AUTH, MAC_ZERO, 1'b1, mk_res(STS_OK, 0, ST_AUTH, 1'b0, MAC_ZERO, '0, 1'b1));
    add_row(CMD_ASSOC, MAC_MID, 1'b1, mk_res(STS_OK, 2, ST_ASSOC, 1'b0, MAC_MID, '0, 1'b1));
    add_row(CMD_TICK, MAC_ZERO, 1'b1,
            mk_res(STS_TICK_DONE, 0, ST_OFF, 1'b0, '0, '0, 1'b1));
    // timers expire: two on-radio stations removed, the associated one just stops
    add_row(CMD_TICK, MAC_ZERO, 1'b0, '0);
    add_row(CMD_TICK, MAC_MID, 1'b1,
            mk_res(STS_TICK_DONE, 0, ST_OFF, 1'b0, '0, '0, 1'b1));
    add_row(CMD_RADIO, MAC_MID, 1'b1, mk_res(STS_OK, 2, ST_ASSOC, 1'b0, MAC_MID, '0, 1'b1));
    add_row(CMD_DEAUTH, MAC_MID, 1'b1,
            mk_res(STS_OK, 2, ST_OFF, 1'b1, MAC_MID, 5'd31, 1'b1));

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    cfg_write(CFG_TIMEOUT, 16'd2);
    cfg_write(CFG_RADIO, {11'($urandom), 5'd31});
    foreach (dir_rows[r]) send_req(dir_rows[r].cmd, dir_rows[r].mac, dir_rows[r].typed,
                                   dir_rows[r].res);

    // Random phases. Each starts from an idle block with new register values.
    // The first one also holds off the result side long enough to back up the
    // request queue; the last one runs with no gaps on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      cfg_write(CFG_TIMEOUT, TIMER_W'(PH_TIMEOUT[p]));
      cfg_write(CFG_RADIO, {11'($urandom),
                            (PH_RADIO[p] < 0) ? 5'($urandom_range(0, 31)) : 5'(PH_RADIO[p])});
      if (p == 0) hold_long = 1'b1;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      random_traffic(PH_LEN[p]);
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("wifi_station_association_table test passed");
    end else begin
      $display("wifi_station_association_table test failed");
    end
    $finish;
  end

endmodule
